/* src/lavm_pkg.sv */
// shared types and codes for the look-at view matrix core
// no dependencies; used by the rows stage, the top level, the checker and the testbench
package lavm_pkg;

    localparam int TOL_W = 17;
    localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_PERP  = 2'd1;
    localparam logic [1:0] ERR_DEGEN = 2'd2;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_DIR   = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] err;
    } t_ctl;

endpackage

/* src/lavm_if.sv */
// valid/ready channel interfaces: input item, result row and register write
// no dependencies
interface lavm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, output ready);
endinterface

interface lavm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic [1:0]         row_index;
    logic               last;
    logic [1:0]         error;

    modport source (output valid, col0, col1, col2, col3, row_index, last, error,
                    input ready);
    modport sink   (input valid, col0, col1, col2, col3, row_index, last, error,
                    output ready);
endinterface

interface lavm_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/lavm_norm.sv */
// pipelined vector normaliser: magnitude scaling, sum of squares,
// one root bit per stage, one quotient bit per stage; no package use
module lavm_norm #(
    parameter int FRAC_BITS = 16,
    parameter int W = 33,
    parameter int SW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [W-1:0]         i_vec [3],
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_vec [3],
    output logic                        o_ok,
    output logic [SW-1:0]               o_side
);
    localparam int DW = FRAC_BITS + 2;
    localparam int QB = DW;
    localparam int NC = (W + 7) / 8;
    localparam int CW = NC * 8;
    localparam int PW = $clog2(CW);
    localparam int SQ = 31;
    localparam int NB = 32 + FRAC_BITS;
    localparam int MW = 30;

    typedef struct packed {
        logic [2:0]          sgn;
        logic [2:0][W-1:0]   mag;
        logic [SW-1:0]       side;
    } t_early;

    typedef struct packed {
        logic [2:0]          sgn;
        logic                fail;
        logic [2:0][MW-1:0]  mag;
        logic [SW-1:0]       side;
    } t_cy;

    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_early        n1_e, r1_e, r2_e, r3_e, r4_e;
    logic [W-1:0]  n2_m, r2_m;
    logic [NC-1:0] n3_nz, r3_nz;
    logic [2:0]    n3_lp [NC];
    logic [2:0]    r3_lp [NC];
    logic [PW-1:0] n4_p, r4_p;
    logic          n4_fail, r4_fail;
    t_cy           n5_c, r5_c, r6_c;
    logic [59:0]   r6_sq [3];
    logic [63:0]   n7_sum;

    logic [63:0]   r_sr [SQ+1];
    logic [SQ-1:0] r_ss [SQ+1];
    t_cy           r_sc [SQ+1];
    logic          r_sv [SQ+1];

    logic [NB-1:0] r_dr [QB+1][3];
    logic [SQ-1:0] r_dl [QB+1];
    logic [QB-1:0] r_dq [QB+1][3];
    t_cy           r_dc [QB+1];
    logic          r_dv [QB+1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_e.sgn[k] = i_vec[k][W-1];
            n1_e.mag[k] = i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k]);
        end
        n1_e.side = i_side;
    end

    always_comb begin
        n2_m = r1_e.mag[0];
        if (r1_e.mag[1] > n2_m) begin
            n2_m = r1_e.mag[1];
        end
        if (r1_e.mag[2] > n2_m) begin
            n2_m = r1_e.mag[2];
        end
    end

    // per-byte leading one, then the highest live byte
    always_comb begin
        logic [CW-1:0] mp;
        mp = CW'(r2_m);
        for (int c = 0; c < NC; c++) begin
            n3_nz[c] = |mp[c*8 +: 8];
            n3_lp[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (mp[c*8 + b]) begin
                    n3_lp[c] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        n4_p = '0;
        for (int c = 0; c < NC; c++) begin
            if (r3_nz[c]) begin
                n4_p = PW'(c * 8 + int'(r3_lp[c]));
            end
        end
        n4_fail = ~|r3_nz;
    end

    // bring the largest magnitude into [2^29, 2^30)
    always_comb begin
        logic [63:0] ext;
        logic [63:0] sh;
        n5_c.sgn  = r4_e.sgn;
        n5_c.fail = r4_fail;
        n5_c.side = r4_e.side;
        for (int k = 0; k < 3; k++) begin
            ext = 64'(r4_e.mag[k]);
            if (int'(r4_p) > MW - 1) begin
                sh = ext >> (int'(r4_p) - (MW - 1));
            end else begin
                sh = ext << ((MW - 1) - int'(r4_p));
            end
            n5_c.mag[k] = sh[MW-1:0];
        end
    end

    assign n7_sum = 64'(r6_sq[0]) + 64'(r6_sq[1]) + 64'(r6_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
            r_sv[0]  <= 1'b0;
            r_dv[0]  <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_v6     <= r_v5;
            r_sv[0]  <= r_v6;
            r_dv[0]  <= r_sv[SQ];
            o_valid  <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_e    <= n1_e;
            r2_e    <= r1_e;
            r2_m    <= n2_m;
            r3_e    <= r2_e;
            r3_nz   <= n3_nz;
            r3_lp   <= n3_lp;
            r4_e    <= r3_e;
            r4_p    <= n4_p;
            r4_fail <= n4_fail;
            r5_c    <= n5_c;
            r6_c    <= r5_c;
            for (int k = 0; k < 3; k++) begin
                r6_sq[k] <= 60'(r5_c.mag[k]) * 60'(r5_c.mag[k]);
            end
            r_sr[0] <= n7_sum;
            r_ss[0] <= '0;
            r_sc[0] <= r6_c;
            r_dl[0] <= r_ss[SQ];
            r_dc[0] <= r_sc[SQ];
            for (int k = 0; k < 3; k++) begin
                // rounding offset of half the length folded into the dividend
                r_dr[0][k] <= (NB'(r_sc[SQ].mag[k]) << FRAC_BITS) + NB'(r_ss[SQ] >> 1);
                r_dq[0][k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                o_vec[k] <= r_dc[QB].sgn[k] ? -$signed(r_dq[QB][k]) : $signed(r_dq[QB][k]);
            end
            o_ok   <= !r_dc[QB].fail;
            o_side <= r_dc[QB].side;
        end
    end

    // floor square root, remainder kept as x - root^2
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam int B = SQ - 1 - k;
        logic [63:0] trial;
        assign trial = (64'(r_ss[k]) << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sc[k+1] <= r_sc[k];
                if (r_sr[k] >= trial) begin
                    r_sr[k+1] <= r_sr[k] - trial;
                    r_ss[k+1] <= r_ss[k] | (SQ'(1) << B);
                end else begin
                    r_sr[k+1] <= r_sr[k];
                    r_ss[k+1] <= r_ss[k];
                end
            end
        end
    end

    // restoring division, three components share the divisor
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [NB-1:0] dv;
        assign dv = NB'(r_dl[j]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dl[j+1] <= r_dl[j];
                r_dc[j+1] <= r_dc[j];
                for (int k = 0; k < 3; k++) begin
                    if (r_dr[j][k] >= dv) begin
                        r_dr[j+1][k] <= r_dr[j][k] - dv;
                        r_dq[j+1][k] <= r_dq[j][k] | (QB'(1) << B);
                    end else begin
                        r_dr[j+1][k] <= r_dr[j][k];
                        r_dq[j+1][k] <= r_dq[j][k];
                    end
                end
            end
        end
    end

endmodule

/* src/lavm_rows.sv */
// translation terms, rounding and saturation, and the three-row output register
// uses lavm_pkg for error and row codes and the control struct
module lavm_rows #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lavm_pkg::t_ctl              i_ctl,
    input  logic signed [FRAC_BITS+1:0] i_axis [3][3],
    input  logic signed [31:0]          i_eye [3],
    input  logic                        i_ready,
    output logic                        o_en,
    output logic                        o_valid,
    output logic signed [31:0]          o_col0,
    output logic signed [31:0]          o_col1,
    output logic signed [31:0]          o_col2,
    output logic signed [31:0]          o_col3,
    output logic [1:0]                  o_row_index,
    output logic                        o_last,
    output logic [1:0]                  o_error
);
    localparam int DW = FRAC_BITS + 2;
    localparam int PD = DW + 32;
    localparam int SD = DW + 34;

    lavm_pkg::t_ctl        r_g_ctl, r_h_ctl, r_i_ctl;
    logic signed [DW-1:0]  r_g_ax [3][3];
    logic signed [DW-1:0]  r_h_ax [3][3];
    logic signed [DW-1:0]  r_i_ax [3][3];
    logic signed [PD-1:0]  r_g_p [3][3];
    logic signed [SD-1:0]  r_h_s [3];
    logic                  r_i_neg [3];
    logic [SD-1:0]         r_i_mag [3];

    logic [SD:0]           n_rnd [3];
    logic signed [31:0]    n_c3 [3];

    logic                  r_sv;
    logic [1:0]            r_row;
    logic [1:0]            r_err;
    logic signed [31:0]    r_col [3][4];
    logic                  w_final;

    assign w_final = (r_err != lavm_pkg::ERR_OK) || (r_row == lavm_pkg::ROW_DIR);
    assign o_en    = !r_sv || (i_ready && w_final);

    // round halves away from zero, then clamp to 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = ((SD+1)'(r_i_mag[i]) + ((SD+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (r_i_neg[i]) begin
                if (n_rnd[i] > (SD+1)'(64'h8000_0000)) begin
                    n_c3[i] = 32'sh8000_0000;
                end else begin
                    n_c3[i] = $signed((~n_rnd[i][31:0]) + 32'd1);
                end
            end else begin
                if (n_rnd[i] > (SD+1)'(64'h7FFF_FFFF)) begin
                    n_c3[i] = 32'sh7FFF_FFFF;
                end else begin
                    n_c3[i] = $signed(n_rnd[i][31:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_ctl.valid <= 1'b0;
            r_h_ctl.valid <= 1'b0;
            r_i_ctl.valid <= 1'b0;
            r_sv          <= 1'b0;
            r_row         <= lavm_pkg::ROW_RIGHT;
        end else if (o_en) begin
            r_g_ctl.valid <= i_ctl.valid;
            r_h_ctl.valid <= r_g_ctl.valid;
            r_i_ctl.valid <= r_h_ctl.valid;
            r_sv          <= r_i_ctl.valid;
            r_row         <= lavm_pkg::ROW_RIGHT;
        end else if (r_sv && i_ready) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_g_ctl.err <= i_ctl.err;
            r_h_ctl.err <= r_g_ctl.err;
            r_i_ctl.err <= r_h_ctl.err;
            r_err       <= r_i_ctl.err;
            r_g_ax      <= i_axis;
            r_h_ax      <= r_g_ax;
            r_i_ax      <= r_h_ax;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_g_p[i][k] <= PD'(i_axis[i][k]) * PD'(i_eye[k]);
                end
                r_h_s[i]   <= SD'(r_g_p[i][0]) + SD'(r_g_p[i][1]) + SD'(r_g_p[i][2]);
                // the term is minus the dot product
                r_i_neg[i] <= !r_h_s[i][SD-1] && (r_h_s[i] != '0);
                r_i_mag[i] <= r_h_s[i][SD-1] ? SD'(-r_h_s[i]) : SD'(r_h_s[i]);
                for (int k = 0; k < 3; k++) begin
                    r_col[i][k] <= (r_i_ctl.err != lavm_pkg::ERR_OK) ? 32'sd0
                                   : 32'(r_i_ax[i][k]);
                end
                r_col[i][3] <= (r_i_ctl.err != lavm_pkg::ERR_OK) ? 32'sd0 : n_c3[i];
            end
        end
    end

    always_comb begin
        unique case (r_row)
            lavm_pkg::ROW_RIGHT: begin
                o_col0 = r_col[0][0];
                o_col1 = r_col[0][1];
                o_col2 = r_col[0][2];
                o_col3 = r_col[0][3];
            end
            lavm_pkg::ROW_UP: begin
                o_col0 = r_col[1][0];
                o_col1 = r_col[1][1];
                o_col2 = r_col[1][2];
                o_col3 = r_col[1][3];
            end
            default: begin
                o_col0 = r_col[2][0];
                o_col1 = r_col[2][1];
                o_col2 = r_col[2][2];
                o_col3 = r_col[2][3];
            end
        endcase
    end

    assign o_valid     = r_sv;
    assign o_row_index = r_row;
    assign o_last      = w_final;
    assign o_error     = r_err;

endmodule

/* src/look_at_view_matrix_core.sv */
// look-at view matrix core: three pipelined normalisers joined by dot and cross stages.
// a good item leaves as three row beats on the result channel, an error item as a single beat.
// up to one item enters the pipeline per cycle, but the whole pipeline stalls while a row
// beat is pending on the result channel, until the last beat of that item is accepted.
// reset: synchronous active-low, clears all valid bits and sets the tolerance to 66.
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lavm_in_if.sink       i_in,
    lavm_cfg_if.sink      i_cfg,
    lavm_out_if.source    o_out
);
    localparam int DW  = FRAC_BITS + 2;
    localparam int PD  = DW + 32;
    localparam int SD  = DW + 34;
    localparam int XW  = PD + 1;
    localparam int RP  = 2 * DW;
    localparam int X3  = RP + 1;
    localparam int SW1 = 192;
    localparam int SW2 = 96 + 3 * DW + 2;
    localparam int SW3 = 96 + 6 * DW + 2;

    logic                            w_en;
    logic [lavm_pkg::TOL_W-1:0]      r_tol;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= lavm_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    // input register and eye - target
    logic                 r_a_v;
    logic signed [31:0]   r_a_eye [3];
    logic signed [31:0]   r_a_up [3];
    logic signed [32:0]   r_a_diff [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_eye[0]  <= i_in.eye_x;
            r_a_eye[1]  <= i_in.eye_y;
            r_a_eye[2]  <= i_in.eye_z;
            r_a_up[0]   <= i_in.up_x;
            r_a_up[1]   <= i_in.up_y;
            r_a_up[2]   <= i_in.up_z;
            r_a_diff[0] <= 33'(i_in.eye_x) - 33'(i_in.target_x);
            r_a_diff[1] <= 33'(i_in.eye_y) - 33'(i_in.target_y);
            r_a_diff[2] <= 33'(i_in.eye_z) - 33'(i_in.target_z);
        end
    end

    // direction
    logic                 w1_v, w1_ok;
    logic signed [DW-1:0] w1_d [3];
    logic [SW1-1:0]       w1_side;
    logic signed [31:0]   w1_eye [3];
    logic signed [31:0]   w1_up [3];

    lavm_norm #(.FRAC_BITS(FRAC_BITS), .W(33), .SW(SW1)) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_v),
        .i_vec   (r_a_diff),
        .i_side  ({r_a_eye[0], r_a_eye[1], r_a_eye[2], r_a_up[0], r_a_up[1], r_a_up[2]}),
        .o_valid (w1_v),
        .o_vec   (w1_d),
        .o_ok    (w1_ok),
        .o_side  (w1_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w1_eye[k] = $signed(w1_side[SW1-1-32*k -: 32]);
            w1_up[k]  = $signed(w1_side[95-32*k -: 32]);
        end
    end

    // perpendicular test and cross(up, d)
    logic                 r_b_v, r_c_v, r_d_v;
    logic [1:0]           r_b_err, r_c_err, r_d_err;
    logic signed [31:0]   r_b_eye [3];
    logic signed [31:0]   r_c_eye [3];
    logic signed [31:0]   r_d_eye [3];
    logic signed [DW-1:0] r_b_d [3];
    logic signed [DW-1:0] r_c_d [3];
    logic signed [DW-1:0] r_d_d [3];
    logic signed [PD-1:0] r_b_pd [3];
    logic signed [PD-1:0] r_b_x [6];
    logic signed [SD-1:0] r_c_s;
    logic signed [XW-1:0] r_c_x [3];
    logic signed [XW-1:0] r_d_x [3];
    logic [SD-1:0]        w_smag;

    assign w_smag = r_c_s[SD-1] ? SD'(-r_c_s) : SD'(r_c_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= w1_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_err <= w1_ok ? lavm_pkg::ERR_OK : lavm_pkg::ERR_DEGEN;
            r_b_eye <= w1_eye;
            r_b_d   <= w1_d;
            for (int k = 0; k < 3; k++) begin
                r_b_pd[k] <= PD'(w1_d[k]) * PD'(w1_up[k]);
            end
            r_b_x[0] <= PD'(w1_up[1]) * PD'(w1_d[2]);
            r_b_x[1] <= PD'(w1_up[2]) * PD'(w1_d[1]);
            r_b_x[2] <= PD'(w1_up[2]) * PD'(w1_d[0]);
            r_b_x[3] <= PD'(w1_up[0]) * PD'(w1_d[2]);
            r_b_x[4] <= PD'(w1_up[0]) * PD'(w1_d[1]);
            r_b_x[5] <= PD'(w1_up[1]) * PD'(w1_d[0]);

            r_c_err  <= r_b_err;
            r_c_eye  <= r_b_eye;
            r_c_d    <= r_b_d;
            r_c_s    <= SD'(r_b_pd[0]) + SD'(r_b_pd[1]) + SD'(r_b_pd[2]);
            r_c_x[0] <= XW'(r_b_x[0]) - XW'(r_b_x[1]);
            r_c_x[1] <= XW'(r_b_x[2]) - XW'(r_b_x[3]);
            r_c_x[2] <= XW'(r_b_x[4]) - XW'(r_b_x[5]);

            // a degenerate direction wins over the perpendicular test
            if (r_c_err == lavm_pkg::ERR_OK && w_smag > (SD'(r_tol) << FRAC_BITS)) begin
                r_d_err <= lavm_pkg::ERR_PERP;
            end else begin
                r_d_err <= r_c_err;
            end
            r_d_eye <= r_c_eye;
            r_d_d   <= r_c_d;
            r_d_x   <= r_c_x;
        end
    end

    // right axis
    logic                 w2_v, w2_ok;
    logic signed [DW-1:0] w2_r [3];
    logic [SW2-1:0]       w2_side;
    logic signed [31:0]   w2_eye [3];
    logic signed [DW-1:0] w2_d [3];
    logic [1:0]           w2_err;

    lavm_norm #(.FRAC_BITS(FRAC_BITS), .W(XW), .SW(SW2)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_vec   (r_d_x),
        .i_side  ({r_d_eye[0], r_d_eye[1], r_d_eye[2], r_d_d[0], r_d_d[1], r_d_d[2],
                   r_d_err}),
        .o_valid (w2_v),
        .o_vec   (w2_r),
        .o_ok    (w2_ok),
        .o_side  (w2_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w2_eye[k] = $signed(w2_side[SW2-1-32*k -: 32]);
            w2_d[k]   = $signed(w2_side[3*DW+1-DW*k -: DW]);
        end
        w2_err = (w2_side[1:0] == lavm_pkg::ERR_OK && !w2_ok) ? lavm_pkg::ERR_DEGEN
                 : w2_side[1:0];
    end

    // cross(d, r)
    logic                 r_e_v, r_f_v;
    logic [1:0]           r_e_err, r_f_err;
    logic signed [31:0]   r_e_eye [3];
    logic signed [31:0]   r_f_eye [3];
    logic signed [DW-1:0] r_e_d [3];
    logic signed [DW-1:0] r_f_d [3];
    logic signed [DW-1:0] r_e_r [3];
    logic signed [DW-1:0] r_f_r [3];
    logic signed [RP-1:0] r_e_x [6];
    logic signed [X3-1:0] r_f_x [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= w2_v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_err  <= w2_err;
            r_e_eye  <= w2_eye;
            r_e_d    <= w2_d;
            r_e_r    <= w2_r;
            r_e_x[0] <= RP'(w2_d[1]) * RP'(w2_r[2]);
            r_e_x[1] <= RP'(w2_d[2]) * RP'(w2_r[1]);
            r_e_x[2] <= RP'(w2_d[2]) * RP'(w2_r[0]);
            r_e_x[3] <= RP'(w2_d[0]) * RP'(w2_r[2]);
            r_e_x[4] <= RP'(w2_d[0]) * RP'(w2_r[1]);
            r_e_x[5] <= RP'(w2_d[1]) * RP'(w2_r[0]);

            r_f_err  <= r_e_err;
            r_f_eye  <= r_e_eye;
            r_f_d    <= r_e_d;
            r_f_r    <= r_e_r;
            r_f_x[0] <= X3'(r_e_x[0]) - X3'(r_e_x[1]);
            r_f_x[1] <= X3'(r_e_x[2]) - X3'(r_e_x[3]);
            r_f_x[2] <= X3'(r_e_x[4]) - X3'(r_e_x[5]);
        end
    end

    // up axis
    logic                 w3_v, w3_ok;
    logic signed [DW-1:0] w3_u [3];
    logic [SW3-1:0]       w3_side;
    lavm_pkg::t_ctl       w3_ctl;
    logic signed [31:0]   w3_eye [3];
    logic signed [DW-1:0] w3_axis [3][3];

    lavm_norm #(.FRAC_BITS(FRAC_BITS), .W(X3), .SW(SW3)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f_v),
        .i_vec   (r_f_x),
        .i_side  ({r_f_eye[0], r_f_eye[1], r_f_eye[2], r_f_d[0], r_f_d[1], r_f_d[2],
                   r_f_r[0], r_f_r[1], r_f_r[2], r_f_err}),
        .o_valid (w3_v),
        .o_vec   (w3_u),
        .o_ok    (w3_ok),
        .o_side  (w3_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w3_eye[k]     = $signed(w3_side[SW3-1-32*k -: 32]);
            w3_axis[0][k] = $signed(w3_side[3*DW+1-DW*k -: DW]);
            w3_axis[1][k] = w3_u[k];
            w3_axis[2][k] = $signed(w3_side[6*DW+1-DW*k -: DW]);
        end
        w3_ctl.valid = w3_v;
        w3_ctl.err   = (w3_side[1:0] == lavm_pkg::ERR_OK && !w3_ok) ? lavm_pkg::ERR_DEGEN
                       : w3_side[1:0];
    end

    lavm_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w3_ctl),
        .i_axis      (w3_axis),
        .i_eye       (w3_eye),
        .i_ready     (o_out.ready),
        .o_en        (w_en),
        .o_valid     (o_out.valid),
        .o_col0      (o_out.col0),
        .o_col1      (o_out.col1),
        .o_col2      (o_out.col2),
        .o_col3      (o_out.col3),
        .o_row_index (o_out.row_index),
        .o_last      (o_out.last),
        .o_error     (o_out.error)
    );

endmodule

/* src/lavm_checker.sv */
// port-level checks on the result sequence of the look-at view matrix core
// attached to look_at_view_matrix_core by the bind at the end of this file
module lavm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_row_index,
    input logic        i_last,
    input logic [1:0]  i_error,
    input logic [31:0] i_col3
);

    // an error beat is a single closing beat at row zero
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error != lavm_pkg::ERR_OK) |->
        (i_last && i_row_index == lavm_pkg::ROW_RIGHT))
        else $error("error beat not a lone last beat");

    // a good item closes exactly on the direction row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error == lavm_pkg::ERR_OK) |->
        (i_last == (i_row_index == lavm_pkg::ROW_DIR)))
        else $error("last flag and row index disagree");

    // rows of one item follow one another without a gap
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=>
        (i_out_valid && i_row_index == $past(i_row_index) + 2'd1))
        else $error("row sequence broken");

    // input side only stalls while a row is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending row");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_row_index) && $stable(i_col3)))
        else $error("stalled beat changed");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_row_index (o_out.row_index),
    .i_last      (o_out.last),
    .i_error     (o_out.error),
    .i_col3      (o_out.col3)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for look_at_view_matrix_core: directed views, tolerance sweeps,
// random cameras and back-pressure; an in-bench view matrix calculator predicts each row
// depends on lavm_pkg and the channel interfaces in lavm_if
module testbench;

    localparam int FRAC      = 16;
    localparam int DRAIN_WAIT = 220;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 500;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] tgt [3];
        logic signed [31:0] up  [3];
    } t_view;

    typedef struct {
        logic signed [31:0] col [4];
        logic [1:0]         row;
        logic               last;
        logic [1:0]         err;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lavm_in_if  in_ch ();
    lavm_out_if out_ch ();
    lavm_cfg_if cfg_ch ();

    look_at_view_matrix_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_row                       rows_due [$];
    logic [lavm_pkg::TOL_W-1:0] tolerance;
    int                         mismatches;
    int                         hold_cycles;
    int                         burst_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------- view matrix calculator ----------------

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input longint v [3], output longint o [3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        // bring the largest magnitude into [2^29, 2^30)
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint dot_of(input longint a [3], input longint b [3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic void cross_of(input longint a [3], input longint b [3],
                                     output longint o [3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic signed [31:0] translation(input longint a [3],
                                                       input longint eye [3]);
        longint t;
        longint unsigned mag;
        t = -dot_of(a, eye);
        mag = (t < 0) ? -t : t;
        mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        if (t < 0) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(-longint'(mag));
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return 32'(mag);
    endfunction

    function automatic void push_error_row(input logic [1:0] code);
        t_row r;
        for (int i = 0; i < 4; i++) r.col[i] = '0;
        r.row  = lavm_pkg::ROW_RIGHT;
        r.last = 1'b1;
        r.err  = code;
        rows_due.push_back(r);
    endfunction

    function automatic void predict_view(input t_view v);
        longint eye [3], up [3], diff [3], d [3], rgt [3], upv [3], tmp [3], axis [3];
        longint s;
        longint unsigned smag;
        t_row r;
        for (int i = 0; i < 3; i++) begin
            eye[i]  = v.eye[i];
            diff[i] = longint'(v.eye[i]) - longint'(v.tgt[i]);
            up[i]   = v.up[i];
        end
        if (!unit_vec(diff, d)) begin
            push_error_row(lavm_pkg::ERR_DEGEN);
            return;
        end
        s = dot_of(d, up);
        smag = (s < 0) ? -s : s;
        if (smag > (longint'(tolerance) << FRAC)) begin
            push_error_row(lavm_pkg::ERR_PERP);
            return;
        end
        cross_of(up, d, tmp);
        if (!unit_vec(tmp, rgt)) begin
            push_error_row(lavm_pkg::ERR_DEGEN);
            return;
        end
        cross_of(d, rgt, tmp);
        if (!unit_vec(tmp, upv)) begin
            push_error_row(lavm_pkg::ERR_DEGEN);
            return;
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                axis[i] = (k == 0) ? rgt[i] : (k == 1) ? upv[i] : d[i];
            end
            for (int i = 0; i < 3; i++) r.col[i] = 32'(axis[i]);
            r.col[3] = translation(axis, eye);
            r.row  = (k == 0) ? lavm_pkg::ROW_RIGHT
                   : (k == 1) ? lavm_pkg::ROW_UP : lavm_pkg::ROW_DIR;
            r.last = (k == 2);
            r.err  = lavm_pkg::ERR_OK;
            rows_due.push_back(r);
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic send_view(input t_view v);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.eye_x    <= v.eye[0];
        in_ch.eye_y    <= v.eye[1];
        in_ch.eye_z    <= v.eye[2];
        in_ch.target_x <= v.tgt[0];
        in_ch.target_y <= v.tgt[1];
        in_ch.target_z <= v.tgt[2];
        in_ch.up_x     <= v.up[0];
        in_ch.up_y     <= v.up[1];
        in_ch.up_z     <= v.up[2];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_view(v);
    endtask

    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [lavm_pkg::TOL_W-1:0] value);
        drain();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        tolerance = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------- item builders ----------------

    function automatic t_view make_view(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
        t_view v;
        v.eye[0] = ex; v.eye[1] = ey; v.eye[2] = ez;
        v.tgt[0] = tx; v.tgt[1] = ty; v.tgt[2] = tz;
        v.up[0]  = ux; v.up[1]  = uy; v.up[2]  = uz;
        return v;
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // up built as an exact integer cross product, so it is nearly perpendicular to d
    function automatic t_view well_formed_view;
        t_view v;
        longint dv [3], w [3], c [3];
        int span;
        span = ($urandom_range(0, 3) == 0) ? 40 : 1000;
        for (int i = 0; i < 3; i++) begin
            dv[i] = rand_span(span);
            w[i]  = rand_span(1000);
            v.tgt[i] = rand_span(1 << 22);
            v.eye[i] = v.tgt[i] + 32'(dv[i]);
        end
        cross_of(dv, w, c);
        for (int i = 0; i < 3; i++) v.up[i] = 32'(c[i]);
        return v;
    endfunction

    function automatic t_view noise_view;
        t_view v;
        for (int i = 0; i < 3; i++) begin
            v.eye[i] = $urandom;
            v.tgt[i] = $urandom;
            v.up[i]  = $urandom;
        end
        return v;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_row exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row beat: row %0d err %0d", out_ch.row_index,
                             out_ch.error);
            end else begin
                exp_r = rows_due.pop_front();
                if (out_ch.col0 !== exp_r.col[0] || out_ch.col1 !== exp_r.col[1] ||
                    out_ch.col2 !== exp_r.col[2] || out_ch.col3 !== exp_r.col[3] ||
                    out_ch.row_index !== exp_r.row || out_ch.last !== exp_r.last ||
                    out_ch.error !== exp_r.err) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("row mismatch: exp %0d %0d %0d %0d row %0d last %0d err %0d",
                                 exp_r.col[0], exp_r.col[1], exp_r.col[2], exp_r.col[3],
                                 exp_r.row, exp_r.last, exp_r.err);
                        $display("              got %0d %0d %0d %0d row %0d last %0d err %0d",
                                 out_ch.col0, out_ch.col1, out_ch.col2, out_ch.col3,
                                 out_ch.row_index, out_ch.last, out_ch.error);
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        int phase;
        phase = ($time / 640) % 3;
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ch.ready <= 1'b0;
        end else if (phase == 0) begin
            out_ch.ready <= 1'b1;
        end else if (phase == 1) begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            out_ch.ready <= ($urandom_range(0, 9) < 3);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        int idle;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed;
        int one;
        int big;
        one = 1 << FRAC;
        big = 32'h7FFF_FFFF;
        send_view(make_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        send_view(make_view(3 * one, 0, 0, 0, 0, 0, 0, 0, one));
        send_view(make_view(0, 2 * one, 0, 0, 0, 0, one, 0, 0));
        send_view(make_view(-one, 0, 0, 0, 0, 0, 0, -one, 0));
        // eye on the target
        send_view(make_view(7, -9, 11, 7, -9, 11, 0, one, 0));
        send_view(make_view(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // up tilted towards the view direction
        send_view(make_view(0, 0, one, 0, 0, 0, 0, one, one));
        send_view(make_view(0, 0, one, 0, 0, 0, 0, 0, one));
        // zero up passes the perpendicular test but has no cross product
        send_view(make_view(0, 0, one, 0, 0, 0, 0, 0, 0));
        // field extremes and translation saturation
        send_view(make_view(big, 0, 0, 32'h8000_0000, 0, 0, 0, big, 0));
        send_view(make_view(32'h8000_0000, 0, 0, big, 0, 0, 0, 32'h8000_0000, 0));
        send_view(make_view(big, big, big, big - one, big, big, 0, 0, big));
        send_view(make_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0001, big, 0, 0));
        send_view(make_view(big, 32'h8000_0000, big, 0, 0, 0, 1, 0, -1));
        send_view(make_view(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_view(make_view(-1, -1, -1, 0, 0, 0, 1, -1, 0));
    endtask

    task automatic test_tolerance;
        int one;
        one = 1 << FRAC;
        write_tolerance(17'd0);
        for (int n = 0; n < 8; n++) send_view(well_formed_view());
        send_view(make_view(0, 0, one, 0, 0, 0, 0, one, 0));
        write_tolerance(17'h10000);
        // up parallel to d now passes the tolerance and fails on the cross product
        send_view(make_view(0, 0, one, 0, 0, 0, 0, 0, one));
        send_view(make_view(0, 0, one, 0, 0, 0, 0, one, one));
        for (int n = 0; n < 10; n++) send_view(noise_view());
        write_tolerance(17'($urandom_range(1, 4000)));
        for (int n = 0; n < 8; n++) send_view(well_formed_view());
    endtask

    task automatic test_random;
        write_tolerance(lavm_pkg::TOL_RESET);
        for (int n = 0; n < 130; n++) begin
            if ($urandom_range(0, 9) < 7) send_view(well_formed_view());
            else send_view(noise_view());
        end
    endtask

    task automatic test_backpressure;
        hold_cycles = HOLD_LEN;
        for (int n = 0; n < 30; n++) send_view(well_formed_view());
        drain();
        for (int n = 0; n < 6; n++) send_view(well_formed_view());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.eye_x   = '0;
        in_ch.eye_y   = '0;
        in_ch.eye_z   = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        in_ch.up_x    = '0;
        in_ch.up_y    = '0;
        in_ch.up_z    = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        tolerance     = lavm_pkg::TOL_RESET;
        mismatches    = 0;
        hold_cycles   = 0;
        burst_left    = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_tolerance();
        test_random();
        test_backpressure();

        drain();
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
